// ----- rtl/eaxe_pkg.sv -----
package eaxe_pkg;

  // Effective address kinds
  localparam logic [3:0] KIND_DREG     = 4'd0;
  localparam logic [3:0] KIND_AREG     = 4'd1;
  localparam logic [3:0] KIND_IND      = 4'd2;
  localparam logic [3:0] KIND_POSTINC  = 4'd3;
  localparam logic [3:0] KIND_PREDEC   = 4'd4;
  localparam logic [3:0] KIND_D16_AN   = 4'd5;
  localparam logic [3:0] KIND_BRIEF_AN = 4'd6;
  localparam logic [3:0] KIND_FULL_AN  = 4'd7;
  localparam logic [3:0] KIND_D16_PC   = 4'd8;
  localparam logic [3:0] KIND_BRIEF_PC = 4'd9;
  localparam logic [3:0] KIND_FULL_PC  = 4'd10;
  localparam logic [3:0] KIND_IMM_W    = 4'd11;
  localparam logic [3:0] KIND_IMM_L    = 4'd12;
  localparam logic [3:0] KIND_ABS_W    = 4'd13;
  localparam logic [3:0] KIND_ABS_L    = 4'd14;

  // Displacement size codes
  localparam logic [1:0] SIZE_ZERO = 2'd0;
  localparam logic [1:0] SIZE_NONE = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_LONG = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_BD    = 2'd2;

  // Mode/register constants
  localparam logic [5:0] MR_D16_AN = 6'o50;
  localparam logic [5:0] MR_IDX_AN = 6'o60;
  localparam logic [5:0] MR_ABS_W  = 6'o70;
  localparam logic [5:0] MR_ABS_L  = 6'o71;
  localparam logic [5:0] MR_D16_PC = 6'o72;
  localparam logic [5:0] MR_IDX_PC = 6'o73;
  localparam logic [5:0] MR_IMM    = 6'o74;

  localparam int MAX_WORDS   = 5;
  localparam int CNT_W       = $clog2(MAX_WORDS + 1);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [5:0]                  mode_reg;
    logic [MAX_WORDS-1:0][15:0]  words;
    logic [CNT_W-1:0]            count;
    logic [1:0]                  status;
  } eaxe_desc_t;

  // True when a 32-bit value does not fit a signed word
  function automatic logic sword_bad(input logic [31:0] v);
    sword_bad = !((&v[31:15]) || !(|v[31:15]));
  endfunction

  // True when a 32-bit value does not fit a signed byte
  function automatic logic sbyte_bad(input logic [31:0] v);
    sbyte_bad = !((&v[31:7]) || !(|v[31:7]));
  endfunction

endpackage

// ----- rtl/eaxe_front.sv -----
module eaxe_front import eaxe_pkg::*; (
  input  logic [3:0]  ea_kind,
  input  logic [2:0]  base_reg,
  input  logic [3:0]  index_reg,
  input  logic        index_long,
  input  logic [1:0]  scale,
  input  logic [31:0] disp_value,
  input  logic [31:0] outer_disp,
  input  logic [1:0]  suppress,
  input  logic [1:0]  bd_size,
  input  logic [1:0]  od_size,
  input  logic        post_index,
  input  logic [31:0] ext_address,
  input  logic        range_check_enable,
  output eaxe_desc_t  desc
);

  logic        pc_rel;
  logic [31:0] disp_eff;
  logic [15:0] idx_part;
  logic [15:0] full_word;
  logic        pi_eff;
  logic [15:0] bdw [2];
  logic [15:0] odw [2];
  logic [2:0]  nb;
  logic [2:0]  no;
  logic [2:0]  rel;
  logic        range_bad;
  logic        bad_bd;

  // Rebase PC-relative displacements on the extension word address
  assign pc_rel   = (ea_kind == KIND_D16_PC) || (ea_kind == KIND_BRIEF_PC) ||
                    (ea_kind == KIND_FULL_PC);
  assign disp_eff = pc_rel ? (disp_value - ext_address) : disp_value;

  // Build the index and full-format words
  assign idx_part  = {index_reg, index_long, scale, 9'd0};
  assign pi_eff    = post_index & ~suppress[0];
  assign full_word = idx_part | 16'h0100 | {8'd0, suppress[1], suppress[0], bd_size,
                                            1'b0, pi_eff, od_size};

  // Split the base and outer displacements into words
  always_comb begin
    bdw[0] = (bd_size == SIZE_LONG) ? disp_eff[31:16] : disp_eff[15:0];
    bdw[1] = disp_eff[15:0];
    odw[0] = (od_size == SIZE_LONG) ? outer_disp[31:16] : outer_disp[15:0];
    odw[1] = outer_disp[15:0];
    nb = (bd_size == SIZE_WORD) ? 3'd1 : ((bd_size == SIZE_LONG) ? 3'd2 : 3'd0);
    no = (od_size == SIZE_WORD) ? 3'd1 : ((od_size == SIZE_LONG) ? 3'd2 : 3'd0);
  end

  // Classify the item, lay out its words and resolve its status
  always_comb begin
    desc.words = '0;
    desc.count = '0;
    range_bad  = 1'b0;
    bad_bd     = 1'b0;
    rel        = '0;
    unique case (ea_kind)
      KIND_DREG, KIND_AREG, KIND_IND, KIND_POSTINC, KIND_PREDEC:
        desc.mode_reg = {ea_kind[2:0], base_reg};
      KIND_D16_AN:   desc.mode_reg = MR_D16_AN | {3'd0, base_reg};
      KIND_BRIEF_AN,
      KIND_FULL_AN:  desc.mode_reg = MR_IDX_AN | {3'd0, base_reg};
      KIND_D16_PC:   desc.mode_reg = MR_D16_PC;
      KIND_BRIEF_PC,
      KIND_FULL_PC:  desc.mode_reg = MR_IDX_PC;
      KIND_IMM_W,
      KIND_IMM_L:    desc.mode_reg = MR_IMM;
      KIND_ABS_W:    desc.mode_reg = MR_ABS_W;
      KIND_ABS_L:    desc.mode_reg = MR_ABS_L;
      default:       desc.mode_reg = {3'd0, base_reg};
    endcase

    unique case (ea_kind)
      KIND_D16_AN, KIND_D16_PC, KIND_ABS_W: begin
        desc.words[0] = disp_eff[15:0];
        desc.count    = CNT_W'(1);
        range_bad     = sword_bad(disp_eff);
      end
      KIND_BRIEF_AN, KIND_BRIEF_PC: begin
        desc.words[0] = idx_part | {8'd0, disp_eff[7:0]};
        desc.count    = CNT_W'(1);
        range_bad     = sbyte_bad(disp_eff);
      end
      KIND_FULL_AN, KIND_FULL_PC: begin
        desc.words[0] = full_word;
        for (int i = 1; i < MAX_WORDS; i++) begin
          rel = 3'(i - 1);
          if (rel < nb) begin
            desc.words[i] = bdw[rel[0]];
          end else begin
            rel = rel - nb;
            desc.words[i] = odw[rel[0]];
          end
        end
        desc.count = CNT_W'(3'd1 + nb + no);
        range_bad  = ((bd_size == SIZE_WORD) && sword_bad(disp_eff)) ||
                     ((od_size == SIZE_WORD) && sword_bad(outer_disp));
        bad_bd     = (bd_size == SIZE_ZERO);
      end
      KIND_IMM_W: begin
        desc.words[0] = disp_eff[15:0];
        desc.count    = CNT_W'(1);
      end
      KIND_IMM_L, KIND_ABS_L: begin
        desc.words[0] = disp_eff[31:16];
        desc.words[1] = disp_eff[15:0];
        desc.count    = CNT_W'(2);
      end
      default: begin
        desc.count = '0;
      end
    endcase

    // Illegal size wins over a range violation
    priority if (bad_bd) begin
      desc.status = STATUS_BD;
    end else if (range_bad && range_check_enable) begin
      desc.status = STATUS_RANGE;
    end else begin
      desc.status = STATUS_OK;
    end
  end

endmodule

// ----- rtl/eaxe_queue.sv -----
module eaxe_queue import eaxe_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  eaxe_desc_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output eaxe_desc_t rd_data,
  output logic       empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  eaxe_desc_t        entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;
  logic              do_wr;
  logic              do_rd;

  assign full    = (fill == CntW'(Depth));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Store the incoming descriptor
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/eaxe_back.sv -----
module eaxe_back import eaxe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  eaxe_desc_t  head,
  input  logic        head_empty,
  output logic        head_pop,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  mode_reg,
  output logic        word_valid,
  output logic [15:0] ext_word,
  output logic [1:0]  status,
  output logic        is_last
);

  logic [CNT_W-1:0] widx;
  logic [CNT_W-1:0] widx_next;
  logic [CNT_W-1:0] n_eff;
  logic             out_valid;
  logic             load;
  logic             last_now;

  // Step through the words of the head descriptor
  assign n_eff     = (head.count == '0) ? CNT_W'(1) : head.count;
  assign last_now  = (widx == n_eff - CNT_W'(1));
  assign load      = !head_empty && (!out_valid || pop);
  assign head_pop  = load && last_now;
  assign widx_next = last_now ? '0 : widx + 1'b1;
  assign empty     = !out_valid;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        widx      <= widx_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output word register
  always_ff @(posedge clk) begin
    if (load) begin
      mode_reg   <= head.mode_reg;
      word_valid <= (head.count != '0);
      ext_word   <= (head.count != '0) ? head.words[widx] : 16'd0;
      status     <= head.status;
      is_last    <= last_now;
    end
  end

endmodule

// ----- rtl/effective_address_extension_encoder_unit.sv -----
// Path: an address is written into the descriptor queue, then loaded into the output word register.
// Throughput: one result per cycle while a descriptor is queued and results are popped; an address
// gives max(1, words) results from the single output word register stepping through the queued words (up to five).
// Input transfers continue while the two-entry descriptor queue has room.
// Reset (synchronous): empties the queue and output, range_check_enable goes to 1.
module effective_address_extension_encoder_unit import eaxe_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  ea_kind,
  input  logic [2:0]  base_reg,
  input  logic [3:0]  index_reg,
  input  logic        index_long,
  input  logic [1:0]  scale,
  input  logic [31:0] disp_value,
  input  logic [31:0] outer_disp,
  input  logic [1:0]  suppress,
  input  logic [1:0]  bd_size,
  input  logic [1:0]  od_size,
  input  logic        post_index,
  input  logic [31:0] ext_address,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  mode_reg,
  output logic        word_valid,
  output logic [15:0] ext_word,
  output logic [1:0]  status,
  output logic        is_last
);

  logic       range_check_enable;
  eaxe_desc_t front_desc;
  eaxe_desc_t head;
  logic       head_empty;
  logic       head_pop;

  // Hold the range check register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      range_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      range_check_enable <= cfg_data;
    end
  end

  eaxe_front u_front (
    .ea_kind            (ea_kind),
    .base_reg           (base_reg),
    .index_reg          (index_reg),
    .index_long         (index_long),
    .scale              (scale),
    .disp_value         (disp_value),
    .outer_disp         (outer_disp),
    .suppress           (suppress),
    .bd_size            (bd_size),
    .od_size            (od_size),
    .post_index         (post_index),
    .ext_address        (ext_address),
    .range_check_enable (range_check_enable),
    .desc               (front_desc)
  );

  eaxe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  eaxe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .mode_reg   (mode_reg),
    .word_valid (word_valid),
    .ext_word   (ext_word),
    .status     (status),
    .is_last    (is_last)
  );

endmodule
